// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int OFF_W = 20;   // pool offsets
  localparam int SZ_W  = 21;   // byte counts
  localparam int TOT_W = 22;   // aligned size plus header, with headroom

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [OFF_W-1:0] start;
    logic [SZ_W-1:0]  size;
    logic             used;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,   // keep entry
    OP_USE,    // mark used, new payload size
    OP_FREE,   // mark free, new payload size
    OP_NEW,    // load new free entry
    OP_SHL,    // take left neighbour (insert)
    OP_SHR1,   // take right neighbour (remove one)
    OP_SHR2    // take neighbour two along (remove two)
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [OFF_W-1:0] start;
    logic [SZ_W-1:0]  size;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GATH,
    S_EXEC
  } state_t;

endpackage

// File: hw/rtl/ffha_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_cell
// One chunk table entry with its own match compare and shift muxing.
// ----------------------------------------------------------------------------
module ffha_cell import ffha_pkg::*; #(
  parameter int POOL_BYTES   = 1048576,
  parameter int HEADER_BYTES = 16,
  parameter bit IS_HEAD      = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_cmd_t        cmd,
  input  logic             mode,    // ACT_ALLOC or ACT_RELEASE
  input  logic [TOT_W-1:0] total,
  input  logic [OFF_W-1:0] key,
  input  entry_t           ent_l,
  input  entry_t           ent_r1,
  input  entry_t           ent_r2,
  output entry_t           ent,
  output logic             match
);

  entry_t ent_r, ent_nxt;
  logic [SZ_W-1:0] pay_off;

  assign ent = ent_r;
  assign pay_off = SZ_W'(ent_r.start) + SZ_W'(HEADER_BYTES);

  always_comb begin
    if (mode == ACT_ALLOC) begin
      match = ent_r.valid && !ent_r.used && (TOT_W'(ent_r.size) >= total);
    end else begin
      match = ent_r.valid && (pay_off == SZ_W'(key));
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      OP_HOLD: ent_nxt = ent_r;
      OP_USE: begin
        ent_nxt.size = cmd.size;
        ent_nxt.used = 1'b1;
      end
      OP_FREE: begin
        ent_nxt.size = cmd.size;
        ent_nxt.used = 1'b0;
      end
      OP_NEW: begin
        ent_nxt.valid = 1'b1;
        ent_nxt.start = cmd.start;
        ent_nxt.size  = cmd.size;
        ent_nxt.used  = 1'b0;
      end
      OP_SHL:  ent_nxt = ent_l;
      OP_SHR1: ent_nxt = ent_r1;
      OP_SHR2: ent_nxt = ent_r2;
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= IS_HEAD;
      ent_r.start <= '0;
      ent_r.size  <= IS_HEAD ? SZ_W'(POOL_BYTES - HEADER_BYTES) : '0;
      ent_r.used  <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// File: hw/rtl/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit byte-pool allocator with coalescing over a row of chunk cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per request, in_action 0 allocates in_request_bytes,
//           1 releases the chunk whose payload starts at in_release_offset.
//   out_* : exactly one result item per request: status, payload offset
//           (zero on failure and on release) and free byte count afterwards.
//   Both channels are valid/ready; an item moves when both are high.
// Sequence:
//   Allocate and release both pass from accept to result through a compare
//   state across all cells, a gather state and an update state in
//   which every cell shifts or rewrites itself. The request is rounded up to
//   the alignment by a mask at accept (ALIGN_BYTES is a power of two).
//   in_ready is high only while the sequencer is idle, so a new request is
//   taken only after the result of the last one has been committed.
// Reset:
//   Synchronous, active low. Cell 0 holds the whole pool as one free chunk,
//   the other cells are empty, the free count is the pool size.
// Stall:
//   A result sits in the output register; the next item is taken meanwhile
//   and waits in its update cycle until that register has been emptied.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int POOL_BYTES   = 1048576,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_CHUNKS   = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [SZ_W-1:0]  in_request_bytes,
  input  logic [OFF_W-1:0] in_release_offset,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [OFF_W-1:0] out_payload_offset,
  output logic [SZ_W-1:0]  out_free_bytes
);

  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

  state_t state_r, state_nxt;

  // latched request
  logic             act_r;
  logic [OFF_W-1:0] off_r;
  logic             big_r;
  logic [TOT_W-1:0] aligned_in;
  logic [TOT_W-1:0] aligned_r, total_r;

  // table state
  logic [CNT_W-1:0] count_r;
  logic [SZ_W-1:0]  free_r;
  logic [MAX_CHUNKS-1:0] match, hit_r, past_r;
  logic [MAX_CHUNKS-1:0] hit_dn, hit_up;
  entry_t ent [MAX_CHUNKS];
  cell_cmd_t cmd [MAX_CHUNKS];
  entry_t sel_r, prv_r, nxt_r;
  logic any_r;

  // output register
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [OFF_W-1:0] out_off_r;
  logic [SZ_W-1:0]  out_free_r;

  logic accept, commit;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_GATH;
      S_GATH: state_nxt = S_EXEC;
      S_EXEC: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    accept   = in_valid && in_ready;
    commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- alignment: round up by masking the low bits ----------------
  assign aligned_in = (TOT_W'(in_request_bytes) + TOT_W'(ALIGN_BYTES - 1))
                      & ~TOT_W'(ALIGN_BYTES - 1);

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_action;
      off_r     <= in_release_offset;
      big_r     <= (TOT_W'(in_request_bytes) > TOT_W'(POOL_BYTES));
      aligned_r <= aligned_in;
      total_r   <= aligned_in + TOT_W'(HEADER_BYTES);
    end
  end

  // ---------------- row of cells ----------------
  genvar gi;
  generate
    for (gi = 0; gi < MAX_CHUNKS; gi++) begin : g_cell
      entry_t e_l, e_r1, e_r2;
      if (gi == 0) begin : g_l0
        assign e_l = '0;
      end else begin : g_l
        assign e_l = ent[gi-1];
      end
      if (gi + 1 < MAX_CHUNKS) begin : g_r1
        assign e_r1 = ent[gi+1];
      end else begin : g_r1z
        assign e_r1 = '0;
      end
      if (gi + 2 < MAX_CHUNKS) begin : g_r2
        assign e_r2 = ent[gi+2];
      end else begin : g_r2z
        assign e_r2 = '0;
      end

      ffha_cell #(
        .POOL_BYTES  (POOL_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .IS_HEAD     (gi == 0)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd[gi]),
        .mode  (act_r),
        .total (total_r),
        .key   (off_r),
        .ent_l (e_l),
        .ent_r1(e_r1),
        .ent_r2(e_r2),
        .ent   (ent[gi]),
        .match (match[gi])
      );
    end
  endgenerate

  // compare: isolate the first matching cell and mark cells beyond it
  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      hit_r  <= match & (~match + MAX_CHUNKS'(1));
      past_r <= ~(((match & (~match + MAX_CHUNKS'(1))) - MAX_CHUNKS'(1))
                  | (match & (~match + MAX_CHUNKS'(1))));
    end
  end

  assign hit_dn = {hit_r[MAX_CHUNKS-2:0], 1'b0};  // bit i: hit at i-1
  assign hit_up = {1'b0, hit_r[MAX_CHUNKS-1:1]};  // bit i: hit at i+1

  // gather the hit entry and both neighbours
  always_ff @(posedge clk) begin
    entry_t s, p, n;
    if (state_r == S_GATH) begin
      s = '0;
      p = '0;
      n = '0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        s = s | (hit_r[i]  ? ent[i] : entry_t'('0));
        p = p | (hit_up[i] ? ent[i] : entry_t'('0));
        n = n | (hit_dn[i] ? ent[i] : entry_t'('0));
      end
      sel_r <= s;
      prv_r <= p;
      nxt_r <= n;
      any_r <= |hit_r;
    end
  end

  // ---------------- decision ----------------
  logic [TOT_W-1:0] sel_sz, prv_sz, nxt_sz, rest;
  logic split, mp, mn, ok;
  logic [1:0] status;
  logic [SZ_W-1:0] free_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [TOT_W-1:0] k_size, p_size;

  always_comb begin
    sel_sz = TOT_W'(sel_r.size);
    prv_sz = TOT_W'(prv_r.size);
    nxt_sz = TOT_W'(nxt_r.size);
    rest   = sel_sz - aligned_r;
    split  = (rest >= TOT_W'(HEADER_BYTES));
    mn     = nxt_r.valid && !nxt_r.used;
    mp     = prv_r.valid && !prv_r.used;
    k_size = mn ? sel_sz + TOT_W'(HEADER_BYTES) + nxt_sz : sel_sz;
    p_size = prv_sz + TOT_W'(HEADER_BYTES) + k_size;
    free_nxt  = free_r;
    count_nxt = count_r;
    if (act_r == ACT_ALLOC) begin
      if (big_r || (total_r > TOT_W'(free_r)) || !any_r) begin
        status = ST_NOSPACE;
      end else if (split && (count_r == CNT_W'(MAX_CHUNKS))) begin
        status = ST_FULL;
      end else begin
        status    = ST_OK;
        free_nxt  = free_r - SZ_W'(total_r);
        count_nxt = count_r + CNT_W'(split);
      end
    end else begin
      if ((off_r == '0) || !any_r || !sel_r.used) begin
        status = ST_IGNORED;
      end else begin
        status    = ST_OK;
        free_nxt  = free_r + SZ_W'(HEADER_BYTES) + sel_r.size;
        count_nxt = count_r - CNT_W'(mn) - CNT_W'(mp);
      end
    end
    ok = commit && (status == ST_OK);
  end

  // per-cell commands
  generate
    for (gi = 0; gi < MAX_CHUNKS; gi++) begin : g_cmd
      always_comb begin
        cmd[gi].op    = OP_HOLD;
        cmd[gi].start = sel_r.start + OFF_W'(total_r);
        cmd[gi].size  = SZ_W'(rest - TOT_W'(HEADER_BYTES));
        if (ok && act_r == ACT_ALLOC) begin
          if (hit_r[gi]) begin
            cmd[gi].op   = OP_USE;
            cmd[gi].size = SZ_W'(aligned_r);
          end else if (split && hit_dn[gi]) begin
            cmd[gi].op = OP_NEW;
          end else if (split && past_r[gi]) begin
            cmd[gi].op = OP_SHL;
          end
        end else if (ok) begin
          if (hit_r[gi]) begin
            if (mp) begin
              cmd[gi].op = mn ? OP_SHR2 : OP_SHR1;
            end else begin
              cmd[gi].op   = OP_FREE;
              cmd[gi].size = SZ_W'(k_size);
            end
          end else if (hit_up[gi] && mp) begin
            cmd[gi].op   = OP_FREE;
            cmd[gi].size = SZ_W'(p_size);
          end else if (past_r[gi]) begin
            if (mp && mn) cmd[gi].op = OP_SHR2;
            else if (mp || mn) cmd[gi].op = OP_SHR1;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
      free_r  <= SZ_W'(POOL_BYTES);
    end else if (commit) begin
      count_r <= count_nxt;
      free_r  <= free_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= status;
      out_off_r    <= (act_r == ACT_ALLOC && status == ST_OK) ?
                      sel_r.start + OFF_W'(HEADER_BYTES) : '0;
      out_free_r   <= free_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_off_r;
  assign out_free_bytes     = out_free_r;

  // ---------------- assertions ----------------
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CHUNKS))
    else $error("chunk count beyond table");

  a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= SZ_W'(POOL_BYTES))
    else $error("free count beyond pool");

  a_hit_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> $onehot0(hit_r))
    else $error("more than one chunk selected");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> count_r == CNT_W'(MAX_CHUNKS))
    else $error("table full reported below capacity");

endmodule
